/* rtl/inline_qos_parameter_list_walker_unit_defines.svh */
// Assertion macros for the parameter list walker checker.
`ifndef INLINE_QOS_PARAMETER_LIST_WALKER_UNIT_DEFINES_SVH
`define INLINE_QOS_PARAMETER_LIST_WALKER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define IQPLW_ASSERT_NOW(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("iqplw check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define IQPLW_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("iqplw check failed");

`endif

/* rtl/iqplw_pkg.sv */
package iqplw_pkg;

   localparam int IDENTITY_BYTES  = 24;
   localparam int ID_WORD_BYTES   = 8;
   localparam int ID_WORDS        = IDENTITY_BYTES / ID_WORD_BYTES;
   localparam int LENGTH_BITS_DEF = 16;

   localparam logic [1:0] CSR_SENTINEL_ID   = 2'd0;
   localparam logic [1:0] CSR_IDENTITY_ID_A = 2'd1;
   localparam logic [1:0] CSR_IDENTITY_ID_B = 2'd2;

   localparam logic [15:0] SENTINEL_ID_RST   = 16'd1;
   localparam logic [15:0] IDENTITY_ID_A_RST = 16'd131;
   localparam logic [15:0] IDENTITY_ID_B_RST = 16'd32783;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_OVERRUN = 2'd1;
   localparam logic [1:0] STATUS_NO_END  = 2'd2;

   localparam logic [1:0] LAST_WORD = 2'(ID_WORDS - 1);

   typedef enum logic [2:0] {
      PH_ID_LO,
      PH_ID_HI,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_SKIP,
      PH_WAIT
   } phase_type;

   typedef struct packed {
      logic [7:0] octet;
      logic       end_of_region;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] payload_offset;
      logic        has_identity;
      logic [63:0] identity_word;
      logic [1:0]  word_index;
      logic        final_result;
   } rsp_type;

endpackage

/* rtl/iqplw_ram.sv */
module iqplw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AddrBits-1:0] wr_addr,
   input  logic [WIDTH-1:0]    wr_data,
   input  logic                rd_en,
   input  logic [AddrBits-1:0] rd_addr,
   output logic [WIDTH-1:0]    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/inline_qos_parameter_list_walker_unit.sv */
// Channel  Direction  Handshake          Payload
// req      in         req_valid/ready    one list byte + end-of-region flag
// rsp      out        rsp_valid/ready    status, offset, one 64-bit identity word
// csr      in         csr_write_en       csr_index, csr_wdata (16 bits)
//
// One byte per cycle; the walker logic updates its counters in the cycle a byte lands.
// A list end queues three results, read one per cycle from the identity word RAM while rsp_ready lets them out.
// While those results drain, a byte that ends a list or completes an identity
// word waits; other bytes still go in at one per cycle.
// Synchronous active-high reset re-arms the walker; the identity RAM needs no clear.
module inline_qos_parameter_list_walker_unit #(
   parameter int LENGTH_BITS = iqplw_pkg::LENGTH_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  iqplw_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output iqplw_pkg::rsp_type rsp_payload,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   import iqplw_pkg::*;

   localparam logic [LENGTH_BITS-1:0] OffsetMax = {LENGTH_BITS{1'b1}};
   localparam int CapBits  = $clog2(IDENTITY_BYTES);
   localparam int WordBits = $clog2(ID_WORD_BYTES);
   localparam int AddrBits = (ID_WORDS > 1) ? $clog2(ID_WORDS) : 1;
   localparam int AccBits  = 8 * (ID_WORD_BYTES - 1);

   // config
   logic [15:0] sent_ff, ida_ff, idb_ff;

   // walker
   phase_type              phase_ff, phase_in;
   logic [15:0]            pid_ff, pid_in;
   logic [7:0]             plen_lo_ff, plen_lo_in;
   logic [16:0]            owed_ff, owed_in;
   logic [LENGTH_BITS-1:0] off_ff, off_in;
   logic                   cap_ff, cap_in;
   logic                   found_ff, found_in;
   logic [CapBits-1:0]     cap_idx_ff, cap_idx_in;
   logic [AccBits-1:0]     acc_ff, acc_in;

   // emitter
   logic [1:0]  snap_status_ff;
   logic [15:0] snap_off_ff;
   logic        snap_has_ff;
   logic        rd_act_ff;
   logic [1:0]  rd_idx_ff;
   logic        rdv_ff;
   logic [1:0]  rdv_idx_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic                   req_fire, busy, load_out, rd_issue;
   logic                   will_fin, will_wr;
   logic                   fin;
   logic [1:0]             fin_status;
   logic [LENGTH_BITS-1:0] off_inc;
   logic [15:0]            plen;
   logic [16:0]            plen_pad;
   logic [16:0]            owed_dec;
   logic                   id_hit;
   logic                   ram_we;
   logic [AddrBits-1:0]    ram_waddr;
   logic [63:0]            ram_wdata, ram_rdata;

   assign off_inc  = (off_ff != OffsetMax) ? off_ff + 1'b1 : off_ff;
   assign plen     = {req_payload.octet, plen_lo_ff};
   assign plen_pad = {1'b0, plen} + {15'd0, 2'(2'd0 - plen[1:0])};
   assign owed_dec = owed_ff - 17'd1;
   assign id_hit   = (pid_ff == ida_ff) || (pid_ff == idb_ff);

   assign will_wr = (phase_ff == PH_SKIP) && cap_ff && (&cap_idx_ff[WordBits-1:0]);

   always_comb begin
      unique case (phase_ff)
         PH_LEN_HI: will_fin = (pid_ff == sent_ff) || req_payload.end_of_region;
         PH_WAIT:   will_fin = 1'b0;
         default:   will_fin = req_payload.end_of_region;
      endcase
   end

   assign busy      = rd_act_ff || rdv_ff;
   assign req_ready = !busy || !(will_fin || will_wr);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      phase_in   = phase_ff;
      pid_in     = pid_ff;
      plen_lo_in = plen_lo_ff;
      owed_in    = owed_ff;
      off_in     = off_ff;
      cap_in     = cap_ff;
      found_in   = found_ff;
      cap_idx_in = cap_idx_ff;
      acc_in     = acc_ff;
      fin        = 1'b0;
      fin_status = STATUS_OK;
      ram_we     = 1'b0;
      ram_waddr  = cap_idx_ff[CapBits-1:WordBits];
      ram_wdata  = {req_payload.octet, acc_ff};
      if (req_fire) begin
         if (phase_ff != PH_WAIT) begin
            off_in = off_inc;
         end
         unique case (phase_ff)
            PH_ID_LO: begin
               pid_in   = {8'd0, req_payload.octet};
               phase_in = PH_ID_HI;
               if (req_payload.end_of_region) begin
                  fin        = 1'b1;
                  fin_status = STATUS_NO_END;
               end
            end
            PH_ID_HI: begin
               pid_in   = {req_payload.octet, pid_ff[7:0]};
               phase_in = PH_LEN_LO;
               if (req_payload.end_of_region) begin
                  fin        = 1'b1;
                  fin_status = STATUS_NO_END;
               end
            end
            PH_LEN_LO: begin
               plen_lo_in = req_payload.octet;
               phase_in   = PH_LEN_HI;
               if (req_payload.end_of_region) begin
                  fin        = 1'b1;
                  fin_status = STATUS_NO_END;
               end
            end
            PH_LEN_HI: begin
               if (pid_ff == sent_ff) begin
                  fin        = 1'b1;
                  fin_status = STATUS_OK;
               end else begin
                  if (id_hit && (plen >= 16'(IDENTITY_BYTES)) && !found_ff) begin
                     cap_in     = 1'b1;
                     found_in   = 1'b1;
                     cap_idx_in = '0;
                  end
                  owed_in  = plen_pad;
                  phase_in = (plen_pad != 17'd0) ? PH_SKIP : PH_ID_LO;
                  if (req_payload.end_of_region) begin
                     fin        = 1'b1;
                     fin_status = (plen != 16'd0) ? STATUS_OVERRUN : STATUS_NO_END;
                  end
               end
            end
            PH_SKIP: begin
               if (cap_ff) begin
                  acc_in = {req_payload.octet, acc_ff[AccBits-1:8]};
                  ram_we = &cap_idx_ff[WordBits-1:0];
                  cap_idx_in = cap_idx_ff + 1'b1;
                  if (cap_idx_ff == CapBits'(IDENTITY_BYTES - 1)) begin
                     cap_in = 1'b0;
                  end
               end
               owed_in = owed_dec;
               if (owed_dec == 17'd0) begin
                  phase_in = PH_ID_LO;
               end
               if (req_payload.end_of_region) begin
                  fin        = 1'b1;
                  fin_status = (owed_dec != 17'd0) ? STATUS_OVERRUN : STATUS_NO_END;
               end
            end
            PH_WAIT: begin
               if (req_payload.end_of_region) begin
                  phase_in = PH_ID_LO;
                  off_in   = '0;
                  cap_in   = 1'b0;
                  found_in = 1'b0;
               end
            end
            default: phase_in = PH_ID_LO;
         endcase
         if (fin) begin
            if (req_payload.end_of_region) begin
               phase_in = PH_ID_LO;
               off_in   = '0;
               cap_in   = 1'b0;
               found_in = 1'b0;
            end else begin
               phase_in = PH_WAIT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_ID_LO;
         pid_ff     <= '0;
         plen_lo_ff <= '0;
         owed_ff    <= '0;
         off_ff     <= '0;
         cap_ff     <= 1'b0;
         found_ff   <= 1'b0;
         cap_idx_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         pid_ff     <= pid_in;
         plen_lo_ff <= plen_lo_in;
         owed_ff    <= owed_in;
         off_ff     <= off_in;
         cap_ff     <= cap_in;
         found_ff   <= found_in;
         cap_idx_ff <= cap_idx_in;
      end
      acc_ff <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff <= SENTINEL_ID_RST;
         ida_ff  <= IDENTITY_ID_A_RST;
         idb_ff  <= IDENTITY_ID_B_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SENTINEL_ID:   sent_ff <= csr_wdata;
            CSR_IDENTITY_ID_A: ida_ff  <= csr_wdata;
            CSR_IDENTITY_ID_B: idb_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   iqplw_ram #(
      .WIDTH(64),
      .DEPTH(ID_WORDS)
   ) u_id_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (rd_issue),
      .rd_addr(AddrBits'(rd_idx_ff)),
      .rd_data(ram_rdata)
   );

   // result drain: read word k, then load the output register
   assign load_out = rdv_ff && (!rsp_valid_ff || rsp_ready);
   assign rd_issue = rd_act_ff && (!rdv_ff || load_out);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_act_ff    <= 1'b0;
         rd_idx_ff    <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire && fin) begin
            rd_act_ff <= 1'b1;
            rd_idx_ff <= '0;
         end else if (rd_issue) begin
            rd_idx_ff <= rd_idx_ff + 2'd1;
            if (rd_idx_ff == LAST_WORD) begin
               rd_act_ff <= 1'b0;
            end
         end
         if (rd_issue) begin
            rdv_ff <= 1'b1;
         end else if (load_out) begin
            rdv_ff <= 1'b0;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && fin) begin
         snap_status_ff <= fin_status;
         snap_off_ff    <= (fin_status == STATUS_OK) ? off_inc[15:0] : 16'd0;
         snap_has_ff    <= (fin_status == STATUS_OK) && found_ff;
      end
      if (rd_issue) begin
         rdv_idx_ff <= rd_idx_ff;
      end
      if (load_out) begin
         rsp_ff.status         <= snap_status_ff;
         rsp_ff.payload_offset <= snap_off_ff;
         rsp_ff.has_identity   <= snap_has_ff;
         rsp_ff.identity_word  <= snap_has_ff ? ram_rdata : 64'd0;
         rsp_ff.word_index     <= rdv_idx_ff;
         rsp_ff.final_result   <= (rdv_idx_ff == LAST_WORD);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* rtl/iqplw_checker.sv */
`include "inline_qos_parameter_list_walker_unit_defines.svh"

module iqplw_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input iqplw_pkg::rsp_type rsp_payload
);

   import iqplw_pkg::*;

   `IQPLW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // the three words of a run come out back to back and in order
   `IQPLW_ASSERT_NEXT(a_word_seq, rsp_valid && rsp_ready && !rsp_payload.final_result, rsp_valid && (rsp_payload.word_index == $past(rsp_payload.word_index) + 2'd1))

   `IQPLW_ASSERT_NOW(a_final_last, rsp_valid, (rsp_payload.word_index != 2'd3) && (rsp_payload.final_result == (rsp_payload.word_index == LAST_WORD)))

   // a failed walk carries no offset or identity
   `IQPLW_ASSERT_NOW(a_fail_zero, rsp_valid && (rsp_payload.status != STATUS_OK), (rsp_payload.payload_offset == 16'd0) && !rsp_payload.has_identity && (rsp_payload.identity_word == 64'd0))

endmodule

bind inline_qos_parameter_list_walker_unit iqplw_checker u_iqplw_checker (.*);
